/* rtl/rpfa_pkg.sv */
// ============================================================================
// rpfa_pkg
// Shared constants, codes and control types of the region page frame
// allocator.
// ============================================================================
package rpfa_pkg;

    localparam int unsigned MAX_REGIONS = 128;
    localparam int unsigned PAGE_BYTES  = 4096;

    localparam int unsigned ADDR_W     = 52;
    localparam int unsigned TYPE_W     = 8;
    localparam int unsigned LEFT_W     = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int unsigned PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int unsigned IDX_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CNT_W      = $clog2(MAX_REGIONS + 1);

    localparam logic [TYPE_W-1:0] ACCEPTED_TYPE_RST = 8'h01;
    localparam logic [ADDR_W-1:0] LOW_LIMIT_RST     = 52'h0_0000_0010_0000;

    typedef enum logic [0:0] {
        CMD_ADD  = 1'b0,
        CMD_TAKE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEPTED_TYPE = 1'b0,
        CFG_LOW_LIMIT     = 1'b1
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GIVEN    = 3'd0,
        ST_KEPT     = 3'd1,
        ST_REJECTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

/* rtl/rpfa_if.sv */
// ============================================================================
// rpfa_if
// Valid/ready channels of the allocator: request, response and
// configuration write.
// ============================================================================
interface rpfa_req_if;
    logic                          valid;
    logic                          ready;
    logic [0:0]                    cmd;
    logic [rpfa_pkg::TYPE_W-1:0]   zone_type;
    logic [rpfa_pkg::ADDR_W-1:0]   zone_base;
    logic [rpfa_pkg::ADDR_W-1:0]   zone_length;

    modport source (output valid, cmd, zone_type, zone_base, zone_length, input ready);
    modport sink   (input valid, cmd, zone_type, zone_base, zone_length, output ready);
endinterface

interface rpfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rpfa_pkg::ADDR_W-1:0]   page_addr;
    logic [rpfa_pkg::STATUS_W-1:0] status;
    logic [rpfa_pkg::LEFT_W-1:0]   regions_left;

    modport source (output valid, page_addr, status, regions_left, input ready);
    modport sink   (input valid, page_addr, status, regions_left, output ready);
endinterface

interface rpfa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rpfa_pkg::CFG_IDX_W-1:0] index;
    logic [rpfa_pkg::ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/region_page_frame_allocator.sv */
// ============================================================================
// region_page_frame_allocator
// Ring of free physical memory regions: appends firmware zones that pass
// the type, size and low-limit checks, and hands out one page at a time
// from the head region.
// ============================================================================
//  channel  dir  payload                                   transaction when
//  req      in   cmd, zone_type, zone_base, zone_length    valid && ready
//  rsp      out  page_addr, status, regions_left           valid && ready
//  cfg      in   index, data                               valid && ready
//
//  Each request takes capture plus head read, then execute plus write
//  back, on one read and one write port of the 128-entry region memory.
//  A new request is taken while the previous response still waits.
//  A stalled response holds execution in the work state.
//  Reset clears head and count and restores the configuration defaults; the
//  region memory is not cleared and only live ring entries are ever used.
//  cfg is always ready.
// ============================================================================
module region_page_frame_allocator (
    input logic          clk,
    input logic          rst_n,
    rpfa_req_if.sink     req,
    rpfa_rsp_if.source   rsp,
    rpfa_cfg_if.sink     cfg
);

    rpfa_pkg::ctrl_cmd_t ctrl_cmd;
    rpfa_pkg::dp_stat_t  dp_stat;

    assign cfg.ready = 1'b1;

    rpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    rpfa_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (ctrl_cmd),
        .stat             (dp_stat),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .req_cmd          (req.cmd),
        .req_zone_type    (req.zone_type),
        .req_zone_base    (req.zone_base),
        .req_zone_length  (req.zone_length),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_page_addr    (rsp.page_addr),
        .rsp_status       (rsp.status),
        .rsp_regions_left (rsp.regions_left)
    );

endmodule

/* rtl/rpfa_ctrl.sv */
// ============================================================================
// rpfa_ctrl
// Transaction sequencer: captures a request, then executes it once the
// response register can take the result.
// ============================================================================
module rpfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  rpfa_pkg::dp_stat_t  stat,
    output rpfa_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                // hold until the response register is free
                cmd.exec = !stat.out_busy;
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/rpfa_dp.sv */
// ============================================================================
// rpfa_dp
// Datapath: configuration registers, region ring memory, head and count
// registers, checks and page arithmetic, response register.
// ============================================================================
module rpfa_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rpfa_pkg::ctrl_cmd_t             cmd,
    output rpfa_pkg::dp_stat_t              stat,
    input  logic                            cfg_we,
    input  logic [rpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpfa_pkg::ADDR_W-1:0]     cfg_data,
    input  logic [0:0]                      req_cmd,
    input  logic [rpfa_pkg::TYPE_W-1:0]     req_zone_type,
    input  logic [rpfa_pkg::ADDR_W-1:0]     req_zone_base,
    input  logic [rpfa_pkg::ADDR_W-1:0]     req_zone_length,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [rpfa_pkg::ADDR_W-1:0]     rsp_page_addr,
    output logic [rpfa_pkg::STATUS_W-1:0]   rsp_status,
    output logic [rpfa_pkg::LEFT_W-1:0]     rsp_regions_left
);

    localparam int unsigned ENT_W = 2 * rpfa_pkg::PAGE_W;
    localparam int unsigned SUM_W = rpfa_pkg::IDX_W + 1;

    logic [rpfa_pkg::TYPE_W-1:0]  accepted_type_reg;
    logic [rpfa_pkg::ADDR_W-1:0]  low_limit_reg;

    rpfa_pkg::cmd_t               cmd_reg;
    logic [rpfa_pkg::TYPE_W-1:0]  type_reg;
    logic [rpfa_pkg::ADDR_W-1:0]  base_reg;
    logic [rpfa_pkg::ADDR_W-1:0]  length_reg;

    logic [ENT_W-1:0]             region_mem [rpfa_pkg::MAX_REGIONS];
    logic [ENT_W-1:0]             rd_data_reg;

    logic [rpfa_pkg::IDX_W-1:0]   head_reg;
    logic [rpfa_pkg::IDX_W-1:0]   head_next;
    logic [rpfa_pkg::CNT_W-1:0]   count_reg;
    logic [rpfa_pkg::CNT_W-1:0]   count_next;

    logic                         out_valid_reg;
    logic [rpfa_pkg::ADDR_W-1:0]  page_addr_reg;
    logic [rpfa_pkg::ADDR_W-1:0]  page_addr_next;
    rpfa_pkg::status_t            status_reg;
    rpfa_pkg::status_t            status_next;
    logic [rpfa_pkg::LEFT_W-1:0]  left_reg;

    logic                         mem_we;
    logic [rpfa_pkg::IDX_W-1:0]   mem_waddr;
    logic [ENT_W-1:0]             mem_wdata;

    logic [rpfa_pkg::PAGE_W-1:0]  zone_pages;
    logic [rpfa_pkg::PAGE_W-1:0]  rd_page;
    logic [rpfa_pkg::PAGE_W-1:0]  rd_left;
    logic [rpfa_pkg::PAGE_W-1:0]  new_left;
    logic [SUM_W-1:0]             slot_sum;
    logic [rpfa_pkg::IDX_W-1:0]   tail_slot;
    logic [rpfa_pkg::IDX_W-1:0]   head_inc;
    logic                         reject;
    logic                         full;

    assign zone_pages = length_reg[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT];
    assign rd_page    = rd_data_reg[ENT_W-1:rpfa_pkg::PAGE_W];
    assign rd_left    = rd_data_reg[rpfa_pkg::PAGE_W-1:0];
    assign new_left   = (rd_left != '0) ? rd_left - 1'b1 : rd_left;

    assign slot_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_slot = (slot_sum >= SUM_W'(rpfa_pkg::MAX_REGIONS))
                     ? rpfa_pkg::IDX_W'(slot_sum - SUM_W'(rpfa_pkg::MAX_REGIONS))
                     : rpfa_pkg::IDX_W'(slot_sum);
    assign head_inc  = (head_reg == rpfa_pkg::IDX_W'(rpfa_pkg::MAX_REGIONS - 1))
                     ? '0 : head_reg + 1'b1;

    assign reject = (type_reg != accepted_type_reg) || (zone_pages == '0)
                 || (base_reg < low_limit_reg);
    assign full   = (count_reg == rpfa_pkg::CNT_W'(rpfa_pkg::MAX_REGIONS));

    always_comb
    begin
        page_addr_next = '0;
        status_next    = rpfa_pkg::ST_REJECTED;
        head_next      = head_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_wdata      = {rd_page + 1'b1, new_left};
        unique case (cmd_reg)
            rpfa_pkg::CMD_ADD:
            begin
                mem_waddr = tail_slot;
                mem_wdata = {base_reg[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT], zone_pages};
                priority if (reject)
                begin
                    status_next = rpfa_pkg::ST_REJECTED;
                end
                else if (full)
                begin
                    status_next = rpfa_pkg::ST_FULL;
                end
                else
                begin
                    status_next = rpfa_pkg::ST_KEPT;
                    mem_we      = cmd.exec;
                    count_next  = count_reg + 1'b1;
                end
            end
            rpfa_pkg::CMD_TAKE:
            begin
                if (count_reg == '0)
                begin
                    status_next = rpfa_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next    = rpfa_pkg::ST_GIVEN;
                    page_addr_next = {rd_page, {rpfa_pkg::PAGE_SHIFT{1'b0}}};
                    mem_we         = cmd.exec;
                    if (new_left == '0)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = rpfa_pkg::ST_REJECTED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            region_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= region_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg    <= rpfa_pkg::cmd_t'(req_cmd);
            type_reg   <= req_zone_type;
            base_reg   <= req_zone_base;
            length_reg <= req_zone_length;
        end
        if (cmd.exec)
        begin
            page_addr_reg <= page_addr_next;
            status_reg    <= status_next;
            left_reg      <= rpfa_pkg::LEFT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_type_reg <= rpfa_pkg::ACCEPTED_TYPE_RST;
            low_limit_reg     <= rpfa_pkg::LOW_LIMIT_RST;
            head_reg          <= '0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (rpfa_pkg::cfg_idx_t'(cfg_index))
                    rpfa_pkg::CFG_ACCEPTED_TYPE:
                        accepted_type_reg <= cfg_data[rpfa_pkg::TYPE_W-1:0];
                    rpfa_pkg::CFG_LOW_LIMIT:
                        low_limit_reg <= cfg_data;
                    default:
                        low_limit_reg <= low_limit_reg;
                endcase
            end
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (cmd.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_busy    = out_valid_reg && !rsp_ready;
    assign rsp_valid        = out_valid_reg;
    assign rsp_page_addr    = page_addr_reg;
    assign rsp_status       = status_reg;
    assign rsp_regions_left = left_reg;

endmodule

/* rtl/rpfa_checker.sv */
// ============================================================================
// rpfa_checker
// Port-level checks on the response channel of the allocator.
// ============================================================================
module rpfa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [rpfa_pkg::ADDR_W-1:0]   rsp_page_addr,
    input logic [rpfa_pkg::STATUS_W-1:0] rsp_status,
    input logic [rpfa_pkg::LEFT_W-1:0]   rsp_regions_left
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_page_addr) && $stable(rsp_status)
                                    && $stable(rsp_regions_left))
        else $error("stalled response changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= rpfa_pkg::STATUS_W'(rpfa_pkg::ST_EMPTY))
        else $error("undefined status code");

    a_addr_only_given: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != rpfa_pkg::STATUS_W'(rpfa_pkg::ST_GIVEN))
        |-> rsp_page_addr == '0)
        else $error("page address without a page handed out");

    a_addr_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_page_addr[rpfa_pkg::PAGE_SHIFT-1:0] == '0)
        else $error("page address not page aligned");

endmodule

bind region_page_frame_allocator rpfa_checker u_rpfa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_page_addr    (rsp.page_addr),
    .rsp_status       (rsp.status),
    .rsp_regions_left (rsp.regions_left)
);

/* verif/rpfa_alloc_checker.sv */
// ============================================================================
// rpfa_alloc_checker
// Watches the request, response and configuration channels of the region
// page frame allocator, keeps its own copy of the region ring and the
// configuration, works out the outcome of every accepted request and
// compares each accepted response with the oldest outstanding outcome.
// ============================================================================
module rpfa_alloc_checker
    import rpfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rpfa_req_if  req,
    rpfa_rsp_if  rsp,
    rpfa_cfg_if  cfg,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic [ADDR_W-1:0] page_addr;
        status_t           status;
        logic [LEFT_W-1:0] regions_left;
    } alloc_outcome_t;

    logic [PAGE_W-1:0] base_page  [MAX_REGIONS];
    logic [PAGE_W-1:0] pages_left [MAX_REGIONS];
    logic [IDX_W-1:0]  head;
    logic [CNT_W-1:0]  held;
    logic [TYPE_W-1:0] usable_type;
    logic [ADDR_W-1:0] floor_addr;
    alloc_outcome_t    outcomes_q [$];

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic alloc_outcome_t serve_request(input cmd_t c,
                                                     input logic [TYPE_W-1:0] t,
                                                     input logic [ADDR_W-1:0] b,
                                                     input logic [ADDR_W-1:0] l);
        logic [PAGE_W-1:0] n;
        logic [IDX_W-1:0]  slot;
        alloc_outcome_t    o;
        n = l[ADDR_W-1:PAGE_SHIFT];
        o.page_addr = '0;
        if (c == CMD_ADD)
        begin
            if (t != usable_type || n == 0 || b < floor_addr)
                o.status = ST_REJECTED;
            else if (held >= MAX_REGIONS)
                o.status = ST_FULL;
            else
            begin
                slot = head + IDX_W'(held);
                base_page[slot]  = b[ADDR_W-1:PAGE_SHIFT];
                pages_left[slot] = n;
                held++;
                o.status = ST_KEPT;
            end
        end
        else if (held == 0)
            o.status = ST_EMPTY;
        else
        begin
            o.page_addr = {base_page[head], {PAGE_SHIFT{1'b0}}};
            base_page[head]++;
            if (pages_left[head] != 0)
                pages_left[head]--;
            // drop the head region once exhausted
            if (pages_left[head] == 0)
            begin
                head++;
                held--;
            end
            o.status = ST_GIVEN;
        end
        o.regions_left = LEFT_W'(held);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_outcome_t want;
        if (!rst_n)
        begin
            head        = '0;
            held        = '0;
            usable_type = ACCEPTED_TYPE_RST;
            floor_addr  = LOW_LIMIT_RST;
            outcomes_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg_idx_t'(cfg.index) == CFG_ACCEPTED_TYPE)
                    usable_type = cfg.data[TYPE_W-1:0];
                else
                    floor_addr = cfg.data;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (outcomes_q.size() == 0)
                    flag_mismatch($sformatf("response with nothing outstanding, status %0d",
                                            rsp.status));
                else
                begin
                    want = outcomes_q.pop_front();
                    if (rsp.page_addr !== want.page_addr)
                        flag_mismatch($sformatf("page_addr got 0x%0h want 0x%0h",
                                                rsp.page_addr, want.page_addr));
                    if (rsp.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                rsp.status, want.status));
                    if (rsp.regions_left !== want.regions_left)
                        flag_mismatch($sformatf("regions_left got %0d want %0d",
                                                rsp.regions_left, want.regions_left));
                end
            end
            if (req.valid && req.ready)
                outcomes_q.push_back(serve_request(cmd_t'(req.cmd), req.zone_type,
                                                   req.zone_base, req.zone_length));
            pending <= outcomes_q.size();
        end
    end

endmodule

/* verif/tb_region_page_frame_allocator.sv */
// ============================================================================
// tb_region_page_frame_allocator
// Stimulus and verdict for the region page frame allocator: directed zone
// and page transactions, then phases of random traffic under changing
// configuration and idling, with a long response hold and drain pauses.
// ============================================================================
module tb_region_page_frame_allocator;
    import rpfa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PHASE_ITEMS = 125;

    logic clk = 1'b0;
    logic rst_n;

    rpfa_req_if req_ch ();
    rpfa_rsp_if rsp_ch ();
    rpfa_cfg_if cfg_ch ();

    int mismatches;
    int pending;

    int unsigned       sender_idle_pct;
    int unsigned       stall_pct;
    int unsigned       hold_asked;
    int unsigned       hold_served;
    int unsigned       hold_left;
    int unsigned       cycle_count;
    logic [TYPE_W-1:0] acc_type_now;
    logic [ADDR_W-1:0] low_limit_now;

    int unsigned       add_bias   [PHASES] = '{80, 85, 10, 10, 60, 90, 5, 5, 50, 40};
    logic [TYPE_W-1:0] type_plan  [PHASES] = '{8'h01, 8'h00, 8'hFF, 8'h01, 8'h00,
                                              8'h01, 8'h80, 8'h00, 8'hFF, 8'h01};
    logic [ADDR_W-1:0] limit_plan [PHASES] = '{52'h100000, 52'h0, 52'h100000, '1, 52'h0,
                                              52'h0, 52'h100000, 52'h0, 52'h0, 52'h100000};

    region_page_frame_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    rpfa_alloc_checker u_alloc_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[region_page_frame_allocator] ERROR");
            $finish;
        end
    end

    // response side: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [ADDR_W-1:0] base_from_floor();
        logic [ADDR_W-1:0] a;
        a = rand_addr();
        if ($urandom_range(3) != 0)
            a[PAGE_SHIFT-1:0] = '0;
        if (a < low_limit_now)
            a = low_limit_now | ADDR_W'(a[PAGE_SHIFT-1:0]);
        return a;
    endfunction

    task automatic send_req(input cmd_t c, input logic [TYPE_W-1:0] t,
                            input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] l);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= c;
        req_ch.zone_type   <= t;
        req_ch.zone_base   <= b;
        req_ch.zone_length <= l;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_regs(input logic [TYPE_W-1:0] t, input logic [ADDR_W-1:0] lim);
        logic [ADDR_W-1:0] junk;
        junk = rand_addr();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_ACCEPTED_TYPE;
        cfg_ch.data  <= {junk[ADDR_W-1:TYPE_W], t};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.index <= CFG_LOW_LIMIT;
        cfg_ch.data  <= lim;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid  <= 1'b0;
        acc_type_now  = t;
        low_limit_now = lim;
    endtask

    task automatic drive_random_item(input int unsigned add_pct, input bit allow_huge);
        logic [TYPE_W-1:0] t;
        logic [ADDR_W-1:0] l;
        int unsigned       pages;
        if ($urandom_range(99) < 8)
        begin
            // noise: keep wide zones out of the ring unless allowed
            t = TYPE_W'($urandom);
            if (t == acc_type_now && !allow_huge)
                t = ~t;
            send_req(cmd_t'($urandom_range(1)), t, rand_addr(), rand_addr());
        end
        else if ($urandom_range(99) < add_pct)
        begin
            t = ($urandom_range(9) == 0) ? TYPE_W'($urandom) : acc_type_now;
            pages = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3);
            l = (ADDR_W'(pages) << PAGE_SHIFT) | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
            if (allow_huge && $urandom_range(9) == 0)
                l = rand_addr();
            send_req(CMD_ADD, t, base_from_floor(), l);
        end
        else
            send_req(CMD_TAKE, TYPE_W'($urandom), rand_addr(), rand_addr());
    endtask

    initial
    begin
        logic [TYPE_W-1:0] t;
        logic [ADDR_W-1:0] lim;
        int unsigned       m;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_ADD;
        req_ch.zone_type   = '0;
        req_ch.zone_base   = '0;
        req_ch.zone_length = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_ACCEPTED_TYPE;
        cfg_ch.data        = '0;
        sender_idle_pct    = 0;
        stall_pct          = 0;
        acc_type_now       = ACCEPTED_TYPE_RST;
        low_limit_now      = LOW_LIMIT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, on the reset configuration
        send_req(CMD_TAKE, 8'h00, '0, '0);
        send_req(CMD_ADD, 8'h00, '0, '0);
        send_req(CMD_ADD, 8'h01, '0, 52'h2000);
        send_req(CMD_ADD, 8'hFF, 52'h100000, 52'h2000);
        send_req(CMD_ADD, 8'hFE, '1, '1);
        send_req(CMD_ADD, 8'h01, 52'hFF000, 52'h2000);
        send_req(CMD_ADD, 8'h01, 52'h100000, 52'hFFF);
        send_req(CMD_ADD, 8'h01, 52'h100000, 52'h1000);
        send_req(CMD_ADD, 8'h01, 52'h200ABC, 52'h2FFF);
        send_req(CMD_ADD, 8'h01, 52'hF_FFFF_FFFF_E000, 52'h3005);
        repeat (7) send_req(CMD_TAKE, 8'h00, '0, '0);
        send_req(CMD_TAKE, 8'hFF, '1, '1);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            m = p % 4;
            sender_idle_pct = (m == 1) ? 47 : (m == 3) ? 14 : 0;
            stall_pct       = (m == 2) ? 47 : (m == 3) ? 14 : 0;
            t   = type_plan[p];
            lim = limit_plan[p];
            if (p == 4)
            begin
                t   = TYPE_W'($urandom);
                lim = ADDR_W'({$urandom_range(255), $urandom});
            end
            if (p == 7)
                lim = rand_addr();
            set_regs(t, lim);
            if (p == 0)
                hold_asked++;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 5 && i % 25 == 0)
                    wait_drained();
                drive_random_item(add_bias[p], p == PHASES - 1);
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[region_page_frame_allocator] OK");
        else
            $display("[region_page_frame_allocator] ERROR");
        $finish;
    end

endmodule
